@@ design/cvt_pkg.sv @@
// Package for the cell-versus-tetrahedron classifier: widths, label codes
// and the structs passed between the datapath and the flag accumulator.
// No dependencies.
package cvt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_WIDTH  = 32;
  localparam int COEF_FRAC   = 24;
  localparam int NUM_REGS    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 2 * COEF_WIDTH;
  localparam int NUM_COEFS   = 2 * NUM_REGS;

  // product of one coordinate and one coefficient, exact
  localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
  localparam int ONE_POS = FRAC_BITS + COEF_FRAC;
  localparam int BASE_W = (PROD_W > ONE_POS + 1) ? PROD_W : ONE_POS + 1;
  // height: three products plus shifted offset
  localparam int H_W = BASE_W + 2;
  // sum of three heights
  localparam int S_W = H_W + 2;

  typedef logic [1:0] label_t;
  localparam label_t CELL_OUTSIDE  = 2'd0;
  localparam label_t CELL_BOUNDARY = 2'd1;
  localparam label_t CELL_INSIDE   = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic                          cell_degenerate;
    logic                          last_vertex;
  } vtx_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] below;
    logic [3:0] above;
    logic       degenerate;
    logic       last;
  } flags_t;

endpackage

@@ design/cvt_if.sv @@
// Handshake interfaces of the classifier: vertex requests, label requests
// and configuration writes. Depends on cvt_pkg.
interface cvt_vertex_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cvt_pkg::COORD_WIDTH-1:0] coord_x;
  logic signed [cvt_pkg::COORD_WIDTH-1:0] coord_y;
  logic signed [cvt_pkg::COORD_WIDTH-1:0] coord_z;
  logic                                  cell_degenerate;
  logic                                  last_vertex;
  modport source (output valid, coord_x, coord_y, coord_z, cell_degenerate, last_vertex,
                  input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, cell_degenerate, last_vertex,
                output ready);
endinterface

interface cvt_label_if;
  logic                   valid;
  logic                   ready;
  cvt_pkg::label_t        cell_label;
  modport source (output valid, cell_label, input ready);
  modport sink (input valid, cell_label, output ready);
endinterface

interface cvt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cvt_pkg::CFG_IDX_W-1:0]     index;
  logic [cvt_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/cvt_xform.sv @@
// Transform datapath: coefficient registers, input stage, products,
// heights and per-plane below/above flags. Depends on cvt_pkg.
module cvt_xform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  cvt_pkg::vtx_t                 in_vtx,
  input  logic                          cfg_we,
  input  logic [cvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cvt_pkg::CFG_DATA_W-1:0] cfg_data,
  output cvt_pkg::flags_t               flags
);
  import cvt_pkg::*;

  localparam logic signed [H_W-1:0] ONE_H = H_W'(1) << ONE_POS;
  localparam logic signed [S_W-1:0] ONE_S = S_W'(1) << ONE_POS;

  logic [CFG_DATA_W-1:0]        xform [NUM_REGS];
  logic signed [COEF_WIDTH-1:0] coef  [NUM_COEFS];

  // stage 1: registered vertex
  logic s1_valid;
  vtx_t s1;
  // stage 2: products
  logic                     s2_valid, s2_deg, s2_last;
  logic signed [PROD_W-1:0] prod [3][3];
  // stage 3: heights
  logic                     s3_valid, s3_deg, s3_last;
  logic signed [H_W-1:0]    h [3];
  logic signed [H_W-1:0]    h_next [3];
  logic signed [S_W-1:0]    sum;
  logic [3:0]               below, above;
  logic signed [COORD_WIDTH-1:0] crd [3];
  // stage 4: flag register
  logic                     flags_valid, flags_deg, flags_last;
  logic [3:0]               flags_below, flags_above;

  assign flags = {flags_valid, flags_below, flags_above, flags_deg, flags_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) xform[i] <= '0;
    end else if (cfg_we && (int'(cfg_index) < NUM_REGS)) begin
      xform[cfg_index] <= cfg_data;
    end
  end

  for (genvar k = 0; k < NUM_COEFS; k++) begin : g_coef
    assign coef[k] = xform[k/2][(k%2)*COEF_WIDTH +: COEF_WIDTH];
  end

  assign crd[0] = s1.coord_x;
  assign crd[1] = s1.coord_y;
  assign crd[2] = s1.coord_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      flags_valid <= 1'b0;
    end else if (adv) begin
      s1_valid    <= in_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      flags_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= in_vtx;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PROD_W'(crd[c]) * PROD_W'(coef[4*r+c]);
        end
      end
      s2_deg  <= s1.cell_degenerate;
      s2_last <= s1.last_vertex;
      for (int r = 0; r < 3; r++) h[r] <= h_next[r];
      s3_deg  <= s2_deg;
      s3_last <= s2_last;
      flags_below <= below;
      flags_above <= above;
      flags_deg   <= s3_deg;
      flags_last  <= s3_last;
    end
  end

  // offset carries coefficient scale only, so align it to the product scale
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      h_next[r] = H_W'(prod[r][0]) + H_W'(prod[r][1]) + H_W'(prod[r][2])
                + (H_W'(coef[4*r+3]) <<< FRAC_BITS);
    end
  end

  // fourth height is 1 - sum: below when sum > 1, above when sum < 0
  always_comb begin
    sum = S_W'(h[0]) + S_W'(h[1]) + S_W'(h[2]);
    for (int p = 0; p < 3; p++) begin
      below[p] = h[p] < 0;
      above[p] = h[p] > ONE_H;
    end
    below[3] = sum > ONE_S;
    above[3] = sum < 0;
  end

endmodule

@@ design/cvt_accum.sv @@
// Per-cell flag accumulation and label output register.
// Depends on cvt_pkg.
module cvt_accum (
  input  logic            clk,
  input  logic            rst,
  input  cvt_pkg::flags_t flags,
  input  logic            out_ready,
  output logic            out_valid,
  output cvt_pkg::label_t out_label,
  output logic            hold
);
  import cvt_pkg::*;

  logic [3:0] plane_all_below, plane_all_above;
  logic       none_below_any, degenerate_seen;
  logic [3:0] all_below_next, all_above_next;
  logic       none_below_next, degenerate_next;
  label_t     label_next;
  logic       adv;

  // a finished cell cannot enter while the previous label is still waiting
  assign hold = flags.valid && flags.last && out_valid && !out_ready;
  assign adv  = !hold;

  always_comb begin
    all_below_next  = plane_all_below & flags.below;
    all_above_next  = plane_all_above & flags.above;
    none_below_next = none_below_any & ~(|flags.below);
    degenerate_next = degenerate_seen | flags.degenerate;
    if (degenerate_next || (|(all_below_next | all_above_next))) begin
      label_next = CELL_OUTSIDE;
    end else if (none_below_next) begin
      label_next = CELL_INSIDE;
    end else begin
      label_next = CELL_BOUNDARY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_all_below <= '1;
      plane_all_above <= '1;
      none_below_any  <= 1'b1;
      degenerate_seen <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (flags.valid && adv) begin
        if (flags.last) begin
          plane_all_below <= '1;
          plane_all_above <= '1;
          none_below_any  <= 1'b1;
          degenerate_seen <= 1'b0;
        end else begin
          plane_all_below <= all_below_next;
          plane_all_above <= all_above_next;
          none_below_any  <= none_below_next;
          degenerate_seen <= degenerate_next;
        end
      end
      if (flags.valid && flags.last && adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flags.valid && flags.last && adv) begin
      out_label <= label_next;
    end
  end

endmodule

@@ design/cell_vs_tetrahedron_classifier_top.sv @@
// Top level of the cell-versus-tetrahedron classifier.
// Depends on cvt_pkg, cvt_if, cvt_xform and cvt_accum.
//
// Usage:
//  - vertex: one request per cell vertex (Q16.16 x/y/z, degenerate flag,
//    last-vertex mark). A new vertex can be taken every cycle unless a stall holds.
//  - label: one request per cell, sent for the vertex marked last:
//    0 = out, 1 = on boundary, 2 = inside.
//  - cfg: writes the six 64-bit transform registers (two signed Q8.24
//    coefficients each, low half first); unknown indexes are dropped.
//    Always ready; write only while no cell is in flight.
// Label path: after the last vertex is taken it passes the input, product,
//   height and flag registers, then the label register.
// Throughput: one vertex per cycle while no stall holds the four-stage datapath.
// Reset: coefficients clear to zero, per-cell flags go to their start
//   values, the pipeline empties and no label is pending.
// Stall: vertices that close no cell keep flowing while a label waits;
//   only a last vertex reaching the label register while the previous
//   label is still held stalls the whole pipeline (vertex.ready drops).
module cell_vs_tetrahedron_classifier_top (
  input  logic         clk,
  input  logic         rst,
  cvt_vertex_if.sink   vertex,
  cvt_label_if.source  label,
  cvt_cfg_if.sink      cfg
);
  import cvt_pkg::*;

  vtx_t   in_vtx;
  flags_t flags;
  logic   hold;
  logic   adv;

  assign adv = !hold;

  assign vertex.ready = adv;
  assign cfg.ready    = 1'b1;

  assign in_vtx.coord_x         = vertex.coord_x;
  assign in_vtx.coord_y         = vertex.coord_y;
  assign in_vtx.coord_z         = vertex.coord_z;
  assign in_vtx.cell_degenerate = vertex.cell_degenerate;
  assign in_vtx.last_vertex     = vertex.last_vertex;

  // transform, heights and per-plane flags
  cvt_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vertex.valid),
    .in_vtx    (in_vtx),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .flags     (flags)
  );

  // per-cell accumulation and label register
  cvt_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .flags     (flags),
    .out_ready (label.ready),
    .out_valid (label.valid),
    .out_label (label.cell_label),
    .hold      (hold)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking bench for cell_vs_tetrahedron_classifier_top: random cells of
// vertices under several transforms, labels checked in order by a scoreboard.
// Depends on cvt_pkg, cvt_if and the classifier RTL.
`timescale 1ns / 100ps

module tb;
  import cvt_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 10;   // margin over the label latency
  localparam int STALL_LIMIT   = 5000; // cycles with no request moving
  localparam int PHASES        = 8;
  localparam int PHASE_VERTS   = 200;
  localparam int PRESSURE_PHASE = 2;

  typedef enum int {XF_ZERO, XF_IDENTITY, XF_SMALL, XF_EXTREME, XF_RANDOM} xform_kind_t;
  typedef enum int {ST_INSIDE, ST_STRADDLE, ST_BOUNDARY, ST_FULL, ST_FAR} cell_style_t;

  // Tracks the per-cell plane flags and holds the labels still owed by the RTL.
  class cell_label_tracker;
    logic [63:0] xform [NUM_REGS];
    logic [3:0]  all_below, all_above;
    bit          none_below, degen_seen;
    label_t      pending_labels [$];
    int          errors;

    function new();
      foreach (xform[i]) xform[i] = '0;
      clear_cell();
      errors = 0;
    endfunction

    function void clear_cell();
      all_below  = 4'hF;
      all_above  = 4'hF;
      none_below = 1'b1;
      degen_seen = 1'b0;
    endfunction

    function void store_xform(int idx, logic [63:0] val);
      if (idx < NUM_REGS) xform[idx] = val;
    endfunction

    function logic signed [COEF_WIDTH-1:0] coef(int k);
      logic [63:0] pair;
      pair = xform[k / 2];
      return (k % 2) ? pair[63:32] : pair[31:0];
    endfunction

    function int pending();
      return pending_labels.size();
    endfunction

    // Heights are kept exact at 128 bits; unit height is 1 << (16 + 24).
    function void take_vertex(logic signed [COORD_WIDTH-1:0] x, y, z, bit degen, last);
      logic signed [127:0] pos [3];
      logic signed [127:0] h [3];
      logic signed [127:0] term, sum, unit;
      logic [3:0] below, above;
      label_t lbl;
      pos[0] = x;
      pos[1] = y;
      pos[2] = z;
      unit = 128'sd1 <<< ONE_POS;
      for (int r = 0; r < 3; r++) begin
        h[r] = coef(4 * r + 3);
        h[r] = h[r] <<< FRAC_BITS;
        for (int p = 0; p < 3; p++) begin
          term = coef(4 * r + p);
          h[r] = h[r] + pos[p] * term;
        end
      end
      sum = h[0] + h[1] + h[2];
      for (int p = 0; p < 3; p++) begin
        below[p] = h[p] < 0;
        above[p] = h[p] > unit;
      end
      // fourth plane: h3 = 1 - sum
      below[3] = sum > unit;
      above[3] = sum < 0;
      all_below &= below;
      all_above &= above;
      if (below != 4'h0) none_below = 1'b0;
      if (degen) degen_seen = 1'b1;
      if (last) begin
        if (degen_seen || ((all_below | all_above) != 4'h0)) lbl = CELL_OUTSIDE;
        else if (none_below) lbl = CELL_INSIDE;
        else lbl = CELL_BOUNDARY;
        pending_labels.push_back(lbl);
        clear_cell();
      end
    endfunction

    function void check_label(label_t got);
      label_t want;
      if (pending_labels.size() == 0) begin
        $display("%0t: label with none expected: expected none actual %0d", $time, got);
        errors++;
      end else begin
        want = pending_labels.pop_front();
        if (got !== want) begin
          $display("%0t: cell_label mismatch: expected %0d actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  cvt_vertex_if vertex ();
  cvt_label_if  label ();
  cvt_cfg_if    cfg ();

  cell_vs_tetrahedron_classifier_top uut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex),
    .label  (label),
    .cfg    (cfg)
  );

  cell_label_tracker tracker = new();

  int src_idle_pct;
  int snk_stall_pct;
  int quiet_cycles;

  always #HALF_PERIOD clk = ~clk;

  // Label side: ready toggles on the falling edge per the current stall rate.
  always @(negedge clk) begin
    label.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Every accepted label is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && label.valid === 1'b1 && label.ready === 1'b1) begin
      tracker.check_label(label.cell_label);
    end
  end

  // Watchdog: any request moving on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (vertex.valid && vertex.ready) || (label.valid && label.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("cell_vs_tetrahedron_classifier_top verification failed");
      $finish;
    end
  end

  // One config write; leaves valid high so back-to-back writes never lower
  // and raise it in the same step. Caller drops valid after the batch.
  task automatic cfg_write(input int idx, input logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx[CFG_IDX_W-1:0];
    cfg.data  <= val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    tracker.store_xform(idx, val);
    @(negedge clk);
  endtask

  function automatic logic [31:0] small_coef(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] extreme_coef();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Loads all six coefficient pairs for one transform flavor.
  task automatic load_xform(input xform_kind_t kind);
    logic [63:0] val;
    logic [31:0] lo_half, hi_half;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (kind)
        XF_ZERO: val = '0;
        XF_IDENTITY: begin
          // diagonal 1.0: coefficient k = 5*r for rows r = 0..2
          lo_half = ((2 * i) % 5 == 0 && (2 * i) % 4 != 3) ? 32'h0100_0000 : 32'h0;
          hi_half = ((2 * i + 1) % 5 == 0 && (2 * i + 1) % 4 != 3) ? 32'h0100_0000 : 32'h0;
          val = {hi_half, lo_half};
        end
        XF_SMALL: begin
          // odd registers carry the row offset in their upper half
          lo_half = small_coef(1 << 25);
          hi_half = (i % 2) ? small_coef(1 << 24) : small_coef(1 << 25);
          val = {hi_half, lo_half};
        end
        XF_EXTREME: val = {extreme_coef(), extreme_coef()};
        default: val = {$urandom, $urandom};
      endcase
      cfg_write(i, val);
    end
    cfg.valid <= 1'b0;
  endtask

  // Vertex request; returns at the falling edge after acceptance with
  // valid still high so the next request can follow back to back.
  task automatic send_vertex(input logic signed [COORD_WIDTH-1:0] x, y, z,
                             input bit degen, input bit last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      vertex.valid <= 1'b0;
      @(negedge clk);
    end
    vertex.valid           <= 1'b1;
    vertex.coord_x         <= x;
    vertex.coord_y         <= y;
    vertex.coord_z         <= z;
    vertex.cell_degenerate <= degen;
    vertex.last_vertex     <= last;
    do @(posedge clk); while (vertex.ready !== 1'b1);
    tracker.take_vertex(x, y, z, degen, last);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed label has come back.
  task automatic drain_labels();
    vertex.valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [31:0] pick_coord(cell_style_t style);
    case (style)
      ST_INSIDE:   return $urandom_range(0, 21845);             // 0 .. 1/3
      ST_STRADDLE: return $urandom_range(0, 98304) - 16384;     // -0.25 .. 1.25
      ST_BOUNDARY: begin
        case ($urandom_range(0, 6))
          0: return 32'h0;
          1: return 32'h0001_0000;
          2: return 32'h0000_8000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0000_0001;
          5: return 32'h0000_FFFF;
          default: return 32'h0001_0001;
        endcase
      end
      ST_FAR:      return $urandom_range(0, 65536) + 131072;    // 2.0 .. 3.0
      default:     return $urandom;
    endcase
  endfunction

  function automatic cell_style_t pick_style();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return ST_INSIDE;
    if (r < 60) return ST_STRADDLE;
    if (r < 75) return ST_BOUNDARY;
    if (r < 85) return ST_FULL;
    return ST_FAR;
  endfunction

  function automatic int pick_cell_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r <= 4) return 4;   // tetrahedron
    if (r <= 8) return 8;   // hexahedron
    return $urandom_range(2, 7);
  endfunction

  task automatic send_cell(input int nverts);
    cell_style_t style;
    style = pick_style();
    for (int v = 0; v < nverts; v++) begin
      send_vertex(pick_coord(style), pick_coord(style), pick_coord(style),
                  $urandom_range(0, 15) == 0, v == nverts - 1);
    end
  endtask

  // Short hand-picked cells with the identity transform: unit heights map
  // straight onto x, y and z.
  task automatic directed_cells();
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] QTR = 32'h0000_4000;
    // reset transform is all zero: every height is zero, so IN unless degenerate
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b1);
    send_vertex(0, 0, 0, 1'b1, 1'b1);
    drain_labels();
    repeat (SETTLE_CYCLES) @(negedge clk);
    load_xform(XF_IDENTITY);
    // writes to indexes past the last register must leave the transform alone
    cfg_write(NUM_REGS, {$urandom, $urandom});
    cfg_write(NUM_REGS + 1, {$urandom, $urandom});
    cfg.valid <= 1'b0;
    // single-vertex cells: interior, a corner (exact equality), outside
    send_vertex(QTR, QTR, QTR, 1'b0, 1'b1);
    send_vertex(ONE, 0, 0, 1'b0, 1'b1);
    send_vertex(-QTR, QTR, QTR, 1'b0, 1'b1);
    // the four corners: IN
    send_vertex(0, 0, 0, 1'b0, 1'b0);
    send_vertex(ONE, 0, 0, 1'b0, 1'b0);
    send_vertex(0, ONE, 0, 1'b0, 1'b0);
    send_vertex(0, 0, ONE, 1'b0, 1'b1);
    // degenerate flag on a middle vertex only: OUT
    send_vertex(QTR, QTR, QTR, 1'b0, 1'b0);
    send_vertex(QTR, 0, QTR, 1'b1, 1'b0);
    send_vertex(0, QTR, QTR, 1'b0, 1'b1);
    // every vertex behind plane 0: OUT
    send_vertex(-QTR, QTR, 0, 1'b0, 1'b0);
    send_vertex(-ONE, 0, QTR, 1'b0, 1'b1);
    // every vertex past the slanted face: OUT
    send_vertex(ONE, ONE, 0, 1'b0, 1'b0);
    send_vertex(ONE, 0, ONE, 1'b0, 1'b1);
    // straddling plane 0: ON
    send_vertex(-QTR, QTR, QTR, 1'b0, 1'b0);
    send_vertex(QTR, QTR, QTR, 1'b0, 1'b1);
    // coordinate extremes
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
  endtask

  initial begin
    xform_kind_t phase_xform [PHASES];
    int verts_in_phase;
    int size;
    bit held_off;

    phase_xform = '{XF_IDENTITY, XF_SMALL, XF_EXTREME, XF_RANDOM,
                    XF_SMALL, XF_ZERO, XF_IDENTITY, XF_SMALL};
    held_off = 1'b0;

    // every input known from time zero
    clk                    = 1'b0;
    rst                    = 1'b1;
    src_idle_pct           = 0;
    snk_stall_pct          = 0;
    quiet_cycles           = 0;
    vertex.valid           = 1'b0;
    vertex.coord_x         = '0;
    vertex.coord_y         = '0;
    vertex.coord_z         = '0;
    vertex.cell_degenerate = 1'b0;
    vertex.last_vertex     = 1'b0;
    label.ready            = 1'b0;
    cfg.valid              = 1'b0;
    cfg.index              = '0;
    cfg.data               = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_cells();

    // Random phases: each one reloads the transform while idle, picks an
    // idling mix and ends on a closed cell so nothing straddles a reload.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_labels();
      repeat (SETTLE_CYCLES) @(negedge clk);
      load_xform(phase_xform[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
        default: begin src_idle_pct = 25; snk_stall_pct = 25; end
      endcase
      verts_in_phase = 0;
      while (verts_in_phase < PHASE_VERTS) begin
        size = pick_cell_size();
        send_cell(size);
        verts_in_phase += size;
        // once, mid-phase, let the label side run completely dry
        if (ph == PRESSURE_PHASE && !held_off && verts_in_phase >= PHASE_VERTS / 2) begin
          drain_labels();
          held_off = 1'b1;
        end
      end
    end

    drain_labels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("cell_vs_tetrahedron_classifier_top verification clean");
    end else begin
      $display("cell_vs_tetrahedron_classifier_top verification failed");
    end
    $finish;
  end

endmodule
